@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tfn_pkg.sv @@
// ---------------------------------------------------------------------------
// tfn_pkg
// Shared types for the triangle face normal pipeline.
// ---------------------------------------------------------------------------
package tfn_pkg;

    localparam int LANES = 3;

    typedef logic [LANES-1:0] lane_mask_t;

    typedef struct packed {
        logic valid;
        logic degen;
    } tfn_ctl_t;

endpackage

@@ sv/triangle_face_normal.sv @@
// ---------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle, rounded to nearest, one per cycle unless the output stalls.
// ---------------------------------------------------------------------------
//  channel  valid       stall       payload
//  in       tri_valid   tri_stall   a_x..c_z
//  out      nrm_valid   nrm_stall   normal_x/y/z, degenerate
//
//  Pipeline: 6 front stages, one cell per result bit, output register.
//  One transfer per cycle sustained while the output is not stalled.
//  Reset clears all valid bits; no data is cleared.
//  A stalled output freezes the whole pipeline; tri_stall follows it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_face_normal #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tri_valid,
    output logic                           tri_stall,
    input  logic signed [COORD_WIDTH-1:0]  a_x,
    input  logic signed [COORD_WIDTH-1:0]  a_y,
    input  logic signed [COORD_WIDTH-1:0]  a_z,
    input  logic signed [COORD_WIDTH-1:0]  b_x,
    input  logic signed [COORD_WIDTH-1:0]  b_y,
    input  logic signed [COORD_WIDTH-1:0]  b_z,
    input  logic signed [COORD_WIDTH-1:0]  c_x,
    input  logic signed [COORD_WIDTH-1:0]  c_y,
    input  logic signed [COORD_WIDTH-1:0]  c_z,
    output logic                           nrm_valid,
    input  logic                           nrm_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
    output logic                           degenerate
);

    localparam int F   = NORMAL_FRAC_BITS;
    localparam int OW  = F + 2;
    localparam int QW  = F + 1;
    localparam int SQW = 4 * (COORD_WIDTH + 1);
    localparam int SW  = SQW + 2;
    localparam int DW  = SQW + 2 * F + 8;
    localparam int NC  = F + 1;

    logic en;

    tfn_pkg::tfn_ctl_t    ctl_w [NC+1];
    logic [SW-1:0]        s_w   [NC+1];
    tfn_pkg::lane_mask_t  neg_w [NC+1];
    logic signed [DW-1:0] d_w   [NC+1][3];
    logic signed [DW-1:0] g_w   [NC+1][3];
    logic [QW-1:0]        q_w   [NC+1][3];

    logic                 vld_reg;
    logic signed [OW-1:0] nx_reg, ny_reg, nz_reg;
    logic                 deg_reg;
    logic signed [OW-1:0] res [3];

    assign en        = !(vld_reg && nrm_stall);
    assign tri_stall = !en;

    tfn_front #(
        .CW (COORD_WIDTH),
        .F  (F),
        .DW (DW),
        .SW (SW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (tri_valid),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_z      (a_z),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_z      (b_z),
        .c_x      (c_x),
        .c_y      (c_y),
        .c_z      (c_z),
        .ctl      (ctl_w[0]),
        .s        (s_w[0]),
        .neg      (neg_w[0]),
        .d        (d_w[0]),
        .g        (g_w[0])
    );

    assign q_w[0][0] = '0;
    assign q_w[0][1] = '0;
    assign q_w[0][2] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        tfn_cell #(
            .J  (F - i),
            .QW (QW),
            .SW (SW),
            .DW (DW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_w[i]),
            .s_in    (s_w[i]),
            .neg_in  (neg_w[i]),
            .d_in    (d_w[i]),
            .g_in    (g_w[i]),
            .q_in    (q_w[i]),
            .ctl_out (ctl_w[i+1]),
            .s_out   (s_w[i+1]),
            .neg_out (neg_w[i+1]),
            .d_out   (d_w[i+1]),
            .g_out   (g_w[i+1]),
            .q_out   (q_w[i+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (ctl_w[NC].degen)
            begin
                res[k] = '0;
            end
            else if (neg_w[NC][k])
            begin
                res[k] = -$signed(OW'(q_w[NC][k]));
            end
            else
            begin
                res[k] = $signed(OW'(q_w[NC][k]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= ctl_w[NC].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= res[0];
            ny_reg  <= res[1];
            nz_reg  <= res[2];
            deg_reg <= ctl_w[NC].degen;
        end
    end

    assign nrm_valid  = vld_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = deg_reg;

    `ASSERT_IMPLIES(a_degen_zero, clk, rst_n, nrm_valid && degenerate,
        normal_x == '0 && normal_y == '0 && normal_z == '0, "degenerate with nonzero normal")
    `ASSERT_ALWAYS(a_stall_src, clk, rst_n, tri_stall == (nrm_valid && nrm_stall),
        "input stall without held output")
    `ASSERT_IMPLIES(a_range, clk, rst_n, nrm_valid,
        normal_x <= $signed(OW'(1) << F) && normal_x >= -$signed(OW'(1) << F),
        "normal component out of range")
    `ASSERT_NEXT(a_hold, clk, rst_n, nrm_valid && nrm_stall,
        nrm_valid && $stable(normal_y) && $stable(degenerate), "held result changed")

endmodule

@@ sv/tfn_front.sv @@
// ---------------------------------------------------------------------------
// tfn_front
// Edges, cross product, squared length and initial residuals per lane.
// ---------------------------------------------------------------------------
module tfn_front #(
    parameter int CW = 16,
    parameter int F  = 14,
    parameter int DW = 2 * (4 * (CW + 1)) + 2 * F + 8,
    parameter int SW = 4 * (CW + 1) + 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [CW-1:0]  a_x,
    input  logic signed [CW-1:0]  a_y,
    input  logic signed [CW-1:0]  a_z,
    input  logic signed [CW-1:0]  b_x,
    input  logic signed [CW-1:0]  b_y,
    input  logic signed [CW-1:0]  b_z,
    input  logic signed [CW-1:0]  c_x,
    input  logic signed [CW-1:0]  c_y,
    input  logic signed [CW-1:0]  c_z,
    output tfn_pkg::tfn_ctl_t     ctl,
    output logic [SW-1:0]         s,
    output tfn_pkg::lane_mask_t   neg,
    output logic signed [DW-1:0]  d [3],
    output logic signed [DW-1:0]  g [3]
);

    localparam int EW  = CW + 1;
    localparam int PW  = 2 * EW;
    localparam int NW  = PW + 1;
    localparam int MW  = PW;
    localparam int SQW = 2 * MW;
    localparam int TSH = 2 * F + 2;

    logic [5:0] vld_reg;
    logic [5:0] vld_next;

    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] f_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [PW-1:0] r_reg [3];
    logic [MW-1:0]        m_reg [3];
    logic [SQW-1:0]       sq_reg [3];
    logic [SQW-1:0]       sq2_reg [3];
    logic [SW-1:0]        s_reg;
    logic [SW-1:0]        s2_reg;
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] g_reg [3];
    tfn_pkg::lane_mask_t  neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic signed [NW-1:0] n_w [3];

    assign vld_next = {vld_reg[4:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n_w[k] = NW'(p_reg[k]) - NW'(r_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= EW'(b_x) - EW'(a_x);
            e_reg[1] <= EW'(b_y) - EW'(a_y);
            e_reg[2] <= EW'(b_z) - EW'(a_z);
            f_reg[0] <= EW'(c_x) - EW'(a_x);
            f_reg[1] <= EW'(c_y) - EW'(a_y);
            f_reg[2] <= EW'(c_z) - EW'(a_z);

            p_reg[0] <= e_reg[1] * f_reg[2];
            r_reg[0] <= e_reg[2] * f_reg[1];
            p_reg[1] <= e_reg[2] * f_reg[0];
            r_reg[1] <= e_reg[0] * f_reg[2];
            p_reg[2] <= e_reg[0] * f_reg[1];
            r_reg[2] <= e_reg[1] * f_reg[0];

            for (int k = 0; k < 3; k++)
            begin
                neg1_reg[k] <= n_w[k][NW-1];
                m_reg[k]    <= n_w[k][NW-1] ? MW'(-n_w[k]) : MW'(n_w[k]);
                sq_reg[k]   <= m_reg[k] * m_reg[k];
                sq2_reg[k]  <= sq_reg[k];
                d_reg[k]    <= $signed(DW'(sq2_reg[k]) << TSH) - $signed(DW'(s_reg));
                g_reg[k]    <= -$signed(DW'(s_reg));
            end
            neg2_reg <= neg1_reg;
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            s_reg    <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            s2_reg   <= s_reg;
        end
    end

    assign ctl.valid = vld_reg[5];
    assign ctl.degen = (s2_reg == '0);
    assign s         = s2_reg;
    assign neg       = neg4_reg;
    assign d         = d_reg;
    assign g         = g_reg;

endmodule

@@ sv/tfn_cell.sv @@
// ---------------------------------------------------------------------------
// tfn_cell
// One rounding-search step: decides one result bit for all three lanes.
// ---------------------------------------------------------------------------
module tfn_cell #(
    parameter int J  = 0,
    parameter int QW = 15,
    parameter int SW = 70,
    parameter int DW = 104
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  tfn_pkg::tfn_ctl_t     ctl_in,
    input  logic [SW-1:0]         s_in,
    input  tfn_pkg::lane_mask_t   neg_in,
    input  logic signed [DW-1:0]  d_in [3],
    input  logic signed [DW-1:0]  g_in [3],
    input  logic [QW-1:0]         q_in [3],
    output tfn_pkg::tfn_ctl_t     ctl_out,
    output logic [SW-1:0]         s_out,
    output tfn_pkg::lane_mask_t   neg_out,
    output logic signed [DW-1:0]  d_out [3],
    output logic signed [DW-1:0]  g_out [3],
    output logic [QW-1:0]         q_out [3]
);

    logic signed [DW-1:0] s_ext;
    logic signed [DW-1:0] cand [3];
    tfn_pkg::tfn_ctl_t    ctl_reg;
    logic [SW-1:0]        s_reg;
    tfn_pkg::lane_mask_t  neg_reg;
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] g_reg [3];
    logic [QW-1:0]        q_reg [3];

    assign s_ext = $signed(DW'(s_in));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cand[k] = d_in[k] - (g_in[k] <<< (J + 2)) - (s_ext <<< (2 * J + 2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= s_in;
            neg_reg <= neg_in;
            for (int k = 0; k < 3; k++)
            begin
                if (!cand[k][DW-1])
                begin
                    d_reg[k] <= cand[k];
                    g_reg[k] <= g_in[k] + (s_ext <<< (J + 1));
                    q_reg[k] <= q_in[k] | (QW'(1) << J);
                end
                else
                begin
                    d_reg[k] <= d_in[k];
                    g_reg[k] <= g_in[k];
                    q_reg[k] <= q_in[k];
                end
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign s_out   = s_reg;
    assign neg_out = neg_reg;
    assign d_out   = d_reg;
    assign g_out   = g_reg;
    assign q_out   = q_reg;

endmodule

@@ sim/triangle_face_normal_tb.sv @@
// ---------------------------------------------------------------------------
// triangle_face_normal_tb
// Self-checking bench for the triangle face normal pipeline. Each accepted
// triangle is turned into an exact rounded unit normal by a local predictor
// and queued. Each output transfer is compared with the oldest entry. The
// run starts with directed triangles: degenerate cases, coordinate extremes
// and axis-aligned faces. It then sends random triangles under several
// idle and stall mixes, with one long output hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_face_normal_tb;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam int NW = FB + 2;
    localparam int LATENCY = FB + 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] v [9];
    } tri_t;

    typedef struct {
        logic signed [NW-1:0] n [3];
        logic                 degen;
    } nrm_t;

    class normal_scoreboard;
        nrm_t normal_q [$];
        int   errors;
        int   degen_seen;
        int   checked;

        function logic [NW-1:0] unit_mag(logic [127:0] m, logic [127:0] s);
            logic [127:0] t;
            logic [127:0] k;
            logic [127:0] prod;
            int lo;
            int hi;
            int mid;
            t = (m * m) << (2 * FB + 2);
            lo = 0;
            hi = 1 << FB;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                k = 128'(2 * mid - 1);
                prod = k * k * s;
                if (prod <= t)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return NW'(lo);
        endfunction

        function void note(tri_t t);
            longint e [3];
            longint f [3];
            longint c [3];
            logic [127:0] m [3];
            logic [127:0] s;
            logic [NW-1:0] q;
            nrm_t r;
            for (int i = 0; i < 3; i++)
            begin
                e[i] = longint'(t.v[3 + i]) - longint'(t.v[i]);
                f[i] = longint'(t.v[6 + i]) - longint'(t.v[i]);
            end
            c[0] = e[1] * f[2] - e[2] * f[1];
            c[1] = e[2] * f[0] - e[0] * f[2];
            c[2] = e[0] * f[1] - e[1] * f[0];
            s = '0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = 128'(c[i] < 0 ? -c[i] : c[i]);
                s = s + m[i] * m[i];
            end
            r.degen = (s == 0);
            for (int i = 0; i < 3; i++)
            begin
                q = r.degen ? '0 : unit_mag(m[i], s);
                r.n[i] = (c[i] < 0) ? -q : q;
            end
            normal_q.push_back(r);
        endfunction

        function void check(nrm_t got);
            nrm_t want;
            if (normal_q.size() == 0)
            begin
                $error("unexpected output transfer");
                errors++;
                return;
            end
            want = normal_q.pop_front();
            checked++;
            if (got.degen)
                degen_seen++;
            if (got.n[0] !== want.n[0])
            begin
                $error("normal_x expected %0d got %0d", want.n[0], got.n[0]);
                errors++;
            end
            if (got.n[1] !== want.n[1])
            begin
                $error("normal_y expected %0d got %0d", want.n[1], got.n[1]);
                errors++;
            end
            if (got.n[2] !== want.n[2])
            begin
                $error("normal_z expected %0d got %0d", want.n[2], got.n[2]);
                errors++;
            end
            if (got.degen !== want.degen)
            begin
                $error("degenerate expected %0b got %0b", want.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic tri_valid = 1'b0;
    logic tri_stall;
    logic signed [CW-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [CW-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [CW-1:0] c_x = '0, c_y = '0, c_z = '0;
    logic nrm_valid;
    logic nrm_stall = 1'b0;
    logic signed [NW-1:0] normal_x, normal_y, normal_z;
    logic degenerate;

    normal_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int cycles = 0;
    int sent = 0;

    triangle_face_normal #(
        .COORD_WIDTH(CW),
        .NORMAL_FRAC_BITS(FB)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .tri_valid(tri_valid),
        .tri_stall(tri_stall),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .nrm_valid(nrm_valid),
        .nrm_stall(nrm_stall),
        .normal_x(normal_x),
        .normal_y(normal_y),
        .normal_z(normal_z),
        .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        tri_t t;
        nrm_t r;
        cycles++;
        if (rst_n && tri_valid && !tri_stall)
        begin
            t.v = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
            sb.note(t);
        end
        if (rst_n && nrm_valid && !nrm_stall)
        begin
            r.n = '{normal_x, normal_y, normal_z};
            r.degen = degenerate;
            sb.check(r);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            nrm_stall = 1'b1;
            hold_cycles--;
        end
        else
            nrm_stall = ($urandom_range(99) < stall_pct);
    end

    task automatic send_tri(tri_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tri_valid = 1'b0;
            @(negedge clk);
        end
        {a_x, a_y, a_z} = {t.v[0], t.v[1], t.v[2]};
        {b_x, b_y, b_z} = {t.v[3], t.v[4], t.v[5]};
        {c_x, c_y, c_z} = {t.v[6], t.v[7], t.v[8]};
        tri_valid = 1'b1;
        do
            @(posedge clk);
        while (tri_stall);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_coords(int p0, int p1, int p2, int p3, int p4,
                               int p5, int p6, int p7, int p8);
        tri_t t;
        t.v = '{CW'(p0), CW'(p1), CW'(p2), CW'(p3), CW'(p4),
                CW'(p5), CW'(p6), CW'(p7), CW'(p8)};
        send_tri(t);
    endtask

    function automatic tri_t random_tri();
        tri_t t;
        int kind;
        int span;
        kind = $urandom_range(9);
        span = (kind < 4) ? 65535 : (kind < 7 ? 511 : 15);
        for (int i = 0; i < 9; i++)
            t.v[i] = (span == 65535) ? CW'($urandom) : CW'($urandom_range(span) - span / 2);
        if (kind == 8)
            t.v[6 + $urandom_range(2)] = t.v[$urandom_range(2)];
        if (kind == 9)
        begin
            for (int i = 0; i < 3; i++)
                t.v[6 + i] = CW'(t.v[i] + 2 * (t.v[3 + i] - t.v[i]));
        end
        return t;
    endfunction

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n)
            send_tri(random_tri());
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // degenerate: all equal, repeated vertex, collinear
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(100, -5, 7, 100, -5, 7, 3, 4, 5);
        send_coords(0, 0, 0, 256, 256, 256, 512, 512, 512);
        send_coords(-32768, -32768, -32768, 32767, 32767, 32767,
                    -32768, -32768, -32768);
        // axis-aligned faces, z in both windings
        send_coords(0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_coords(0, 0, 0, 0, 256, 0, 256, 0, 0);
        send_coords(0, 0, 0, 0, 256, 0, 0, 0, 256);
        send_coords(0, 0, 0, 0, 0, 256, 256, 0, 0);
        // coordinate extremes, largest edges
        send_coords(-32768, -32768, -32768, 32767, -32768, -32768,
                    -32768, 32767, -32768);
        send_coords(32767, 32767, 32767, -32768, 32767, 32767,
                    32767, -32768, 32767);
        send_coords(-32768, 32767, -32768, 32767, -32768, 32767,
                    32767, 32767, -32768);
        send_coords(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
        send_coords(-1, -1, -1, 1, 0, 0, 0, 1, 0);
        send_coords(0, 0, 0, 1, 1, 1, 1, 1, 2);
        send_coords(0, 0, 0, 1, 0, 0, 0, 1, 1);
        send_coords(5, 9, -3, 6, 9, -3, 5, 9, -2);

        run_phase(500, 0, 0);
        run_phase(500, 56, 0);
        run_phase(500, 0, 56);
        // long output hold-off while input keeps offering
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        run_phase(100, 0, 0);
        run_phase(500, 26, 26);

        tri_valid = 1'b0;
        stall_pct = 0;
        while (sb.normal_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("Sent %0d triangles, checked %0d normals, %0d degenerate.",
                 sent, sb.checked, sb.degen_seen);
        $display("Phases: free-running, sender gaps, receiver stalls, hold-off, mixed.");
        if (sb.errors == 0 && sb.normal_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
